// ===== src/rmss_pkg.sv =====
package rmss_pkg;

    // Internal duty resolution; the sample and the reported duty stay 8 bits.
    localparam int DUTY_BITS = 8;

    localparam int SAMPLE_BITS = 8;
    localparam int OUT_BITS    = 13;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;

    typedef logic [DUTY_BITS-1:0]   duty_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_BUTTON = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_STOP_FWD = 2'd0,
        MODE_RUN_FWD  = 2'd1,
        MODE_STOP_REV = 2'd2,
        MODE_RUN_REV  = 2'd3
    } mode_t;

    // Knob sample to duty scale: the top DUTY_BITS bits of {sample, zeros}
    // give a left shift for wide duty and a right shift for narrow duty.
    function automatic duty_t scale_in(input sample_t s);
        logic [SAMPLE_BITS+DUTY_BITS-1:0] wide;
        wide = {s, {DUTY_BITS{1'b0}}};
        return wide[SAMPLE_BITS+DUTY_BITS-1 -: DUTY_BITS];
    endfunction

    // Duty back to 8 bits, same trick the other way round.
    function automatic sample_t scale_out(input duty_t d);
        logic [SAMPLE_BITS+DUTY_BITS-1:0] wide;
        wide = {d, {SAMPLE_BITS{1'b0}}};
        return wide[SAMPLE_BITS+DUTY_BITS-1 -: SAMPLE_BITS];
    endfunction

endpackage

// ===== src/reversing_motor_soft_start_core.sv =====
// Reversing motor controller with soft start, one event word in, one status word out.
// The status word for an event is registered and is on m_tdata in the cycle after the event is taken.
// Throughput: one event per cycle while m_tready is high; the state update and the output register share one edge.
// s_tready stays high while the output register is empty or being drained.
// Reset (rst_n low, asynchronous): stopped-forward, duty, target, sample and LED zero,
// bridge disabled and set forward, output register empty.
module reversing_motor_soft_start_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] speed_sample
    input  logic [1:0]                          s_tuser,  // [1:0] func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] duty_out, [8] drive_enabled, [9] drive_reverse, [11:10] run_state,
    // [12] led_level, [15:13] zero
    output logic [rmss_pkg::OUT_BYTES*8-1:0]    m_tdata
);
    import rmss_pkg::*;

    // Controller state
    mode_t   mode_reg,     mode_next;
    duty_t   duty_reg,     duty_next;
    duty_t   target_reg,   target_next;
    duty_t   sample_reg,   sample_next;
    logic    led_reg,      led_next;
    logic    drive_en_reg, drive_en_next;
    logic    drive_rev_reg, drive_rev_next;

    // Output register
    logic                     m_valid_reg;
    logic [OUT_BYTES*8-1:0]   m_data_reg;

    logic    accept;
    func_t   func;
    logic    duty_zero;
    logic    stopped_next;

    assign func     = func_t'(s_tuser);
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign duty_zero = (duty_reg == '0);

    // Event decode: one pass, result of the event computed from current state.
    always_comb
    begin
        mode_next      = mode_reg;
        duty_next      = duty_reg;
        target_next    = target_reg;
        sample_next    = sample_reg;
        led_next       = led_reg;
        drive_en_next  = drive_en_reg;
        drive_rev_next = drive_rev_reg;

        case (func)
            FUNC_TICK:
            begin
                // soft start / stop: one step towards the target
                if (target_reg > duty_reg)
                    duty_next = duty_reg + duty_t'(1);
                else if (target_reg < duty_reg)
                    duty_next = duty_reg - duty_t'(1);
            end
            FUNC_SAMPLE:
            begin
                sample_next = scale_in(sample_t'(s_tdata));
                if (mode_reg == MODE_RUN_FWD || mode_reg == MODE_RUN_REV)
                    target_next = sample_next;
            end
            FUNC_BUTTON:
            begin
                led_next = !led_reg;
                case (mode_reg)
                    MODE_STOP_FWD:
                    begin
                        // only restart once the ramp-down has finished
                        if (duty_zero)
                        begin
                            mode_next      = MODE_RUN_FWD;
                            drive_en_next  = 1'b1;
                            drive_rev_next = 1'b0;
                            target_next    = sample_reg;
                        end
                    end
                    MODE_STOP_REV:
                    begin
                        if (duty_zero)
                        begin
                            mode_next      = MODE_RUN_REV;
                            drive_en_next  = 1'b1;
                            drive_rev_next = 1'b1;
                            target_next    = sample_reg;
                        end
                    end
                    MODE_RUN_FWD:
                    begin
                        mode_next   = MODE_STOP_REV;
                        target_next = '0;
                    end
                    default:
                    begin
                        mode_next   = MODE_STOP_FWD;
                        target_next = '0;
                    end
                endcase
            end
            default:
            begin
                // unused event kind: report state unchanged
            end
        endcase

        // bridge off once stopped and fully ramped down; direction is kept
        stopped_next = (mode_next == MODE_STOP_FWD) || (mode_next == MODE_STOP_REV);
        if (duty_next == '0 && stopped_next)
            drive_en_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STOP_FWD;
            duty_reg      <= '0;
            target_reg    <= '0;
            sample_reg    <= '0;
            led_reg       <= 1'b0;
            drive_en_reg  <= 1'b0;
            drive_rev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                duty_reg      <= duty_next;
                target_reg    <= target_next;
                sample_reg    <= sample_next;
                led_reg       <= led_next;
                drive_en_reg  <= drive_en_next;
                drive_rev_reg <= drive_rev_next;
                m_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Status word, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            m_data_reg <= (OUT_BYTES*8)'({led_next, mode_next, drive_rev_next,
                                          drive_en_next, scale_out(duty_next)});
    end

    // Bridge must be off whenever stopped at zero duty
    a_off_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_reg == '0 && (mode_reg == MODE_STOP_FWD || mode_reg == MODE_STOP_REV))
        |-> !drive_en_reg)
        else $error("bridge enabled while stopped at zero duty");

    // Running implies the bridge is enabled
    a_on_when_run: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_RUN_FWD || mode_reg == MODE_RUN_REV) |-> drive_en_reg)
        else $error("running with bridge disabled");

    // Direction bit follows the run state while running
    a_dir_match: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_RUN_FWD && !drive_rev_reg)
        || (mode_reg == MODE_RUN_REV && drive_rev_reg)
        || mode_reg == MODE_STOP_FWD || mode_reg == MODE_STOP_REV)
        else $error("bridge direction disagrees with run state");

    // Soft start: duty never moves by more than one step per cycle
    a_duty_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (duty_reg == $past(duty_reg))
              || (duty_reg == $past(duty_reg) + duty_t'(1))
              || (duty_reg == $past(duty_reg) - duty_t'(1)))
        else $error("duty jumped by more than one step");

endmodule
